### rtl/ddp_header_classifier_top_assert.svh
`ifndef DDP_HEADER_CLASSIFIER_TOP_ASSERT_SVH
`define DDP_HEADER_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define DDPHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define DDPHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ddphc_pkg.sv
package ddphc_pkg;

  localparam int unsigned HEADER_BYTES   = 10;
  localparam int unsigned TIMECODE_BYTES = 4;

  localparam logic [7:0] ID_DEFAULT = 8'd1;
  localparam logic [7:0] ID_STATUS  = 8'd251;
  localparam logic [7:0] ID_DMX     = 8'd254;
  localparam logic [7:0] ID_ALL     = 8'd255;

  localparam int unsigned FLAG_PUSH     = 0;
  localparam int unsigned FLAG_QUERY    = 1;
  localparam int unsigned FLAG_REPLY    = 2;
  localparam int unsigned FLAG_STORAGE  = 3;
  localparam int unsigned FLAG_TIMECODE = 4;

  localparam logic [1:0] CFG_PAUSE_DATA    = 2'd0;
  localparam logic [1:0] CFG_REPLY_VERSION = 2'd1;

  typedef enum logic [2:0] {
    ACT_SHORT_DROP = 3'd0,
    ACT_BAD_SEQ    = 3'd1,
    ACT_STATUS_QRY = 3'd2,
    ACT_OTHER_QRY  = 3'd3,
    ACT_PIXEL      = 3'd4,
    ACT_DMX        = 3'd5,
    ACT_SKIPPED    = 3'd6
  } action_t;

  typedef struct packed {
    logic [7:0]  flags_byte;
    logic [7:0]  control_byte;
    logic [7:0]  type_byte;
    logic [7:0]  dest_id;
    logic [31:0] offset_word;
    logic [15:0] length_word;
    logic [15:0] datagram_length;
    logic [7:0]  first_payload_byte;
  } hdr_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  reply_flags;
    logic [7:0]  reply_id;
    logic [2:0]  pixel_format;
    logic [5:0]  bits_per_element;
    logic [31:0] data_offset;
    logic [15:0] payload_length;
    logic        is_final;
    logic [7:0]  start_code;
    logic [3:0]  payload_start;
  } res_t;

  typedef struct packed {
    logic       write;
    logic [3:0] value;
  } seq_upd_t;

  function automatic logic [5:0] elem_bits(input logic [2:0] code);
    logic [5:0] bits;
    case (code)
      3'd1:    bits = 6'd1;
      3'd2:    bits = 6'd4;
      3'd3:    bits = 6'd8;
      3'd4:    bits = 6'd16;
      3'd5:    bits = 6'd24;
      3'd6:    bits = 6'd32;
      default: bits = 6'd0;
    endcase
    return bits;
  endfunction

endpackage

### rtl/ddphc_in_reg.sv
module ddphc_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          hdr_valid,
  output logic          hdr_stall,
  input  ddphc_pkg::hdr_t hdr_in,
  input  logic          take,
  output logic          held_valid,
  output ddphc_pkg::hdr_t held
);
  import ddphc_pkg::*;

  logic accept;

  assign hdr_stall = held_valid && !take;
  assign accept    = hdr_valid && !hdr_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= hdr_in;
    end
  end

endmodule

### rtl/ddphc_classify.sv
module ddphc_classify (
  input  ddphc_pkg::hdr_t     hdr,
  input  logic [3:0]          last_sequence,
  input  logic                pause_data,
  input  logic [1:0]          reply_version,
  output ddphc_pkg::res_t     res,
  output ddphc_pkg::seq_upd_t seq_upd
);
  import ddphc_pkg::*;

  logic [3:0]  seq;
  logic [3:0]  expect_seq;
  logic        seq_good;
  logic        timecode;
  logic [3:0]  start;
  logic [16:0] need;
  logic        too_short;

  assign seq        = hdr.control_byte[3:0];
  assign expect_seq = (last_sequence == 4'd15) ? 4'd1 : last_sequence + 4'd1;
  assign seq_good   = (seq == 4'd0) || (seq == expect_seq);
  assign timecode   = hdr.flags_byte[FLAG_TIMECODE];
  assign start      = timecode ? 4'(HEADER_BYTES + TIMECODE_BYTES) : 4'(HEADER_BYTES);
  assign need       = {13'd0, start} + {1'b0, hdr.length_word};
  assign too_short  = need > {1'b0, hdr.datagram_length};

  assign seq_upd.write = !too_short;
  assign seq_upd.value = seq;

  always_comb begin
    res               = '0;
    res.action        = ACT_SHORT_DROP;
    res.payload_start = start;
    if (too_short) begin
      res.action = ACT_SHORT_DROP;
    end else if (!seq_good) begin
      res.action = ACT_BAD_SEQ;
    end else if (hdr.flags_byte[FLAG_QUERY]) begin
      res.action      = (hdr.dest_id == ID_STATUS) ? ACT_STATUS_QRY : ACT_OTHER_QRY;
      res.reply_flags = {reply_version, 6'd0};
      res.reply_flags[FLAG_REPLY] = 1'b1;
      res.reply_flags[FLAG_PUSH]  = 1'b1;
      res.reply_id    = hdr.dest_id;
    end else if (pause_data || hdr.flags_byte[FLAG_STORAGE]) begin
      res.action = ACT_SKIPPED;
    end else if (hdr.dest_id == ID_DMX) begin
      res.action         = ACT_DMX;
      res.data_offset    = hdr.offset_word;
      res.payload_length = (hdr.length_word != 16'd0) ? hdr.length_word - 16'd1 : 16'd0;
      res.start_code     = hdr.first_payload_byte;
    end else if (hdr.dest_id == ID_ALL || hdr.dest_id == ID_DEFAULT) begin
      res.action           = ACT_PIXEL;
      res.pixel_format     = hdr.type_byte[5:3];
      res.bits_per_element = elem_bits(hdr.type_byte[2:0]);
      res.data_offset      = hdr.offset_word;
      res.payload_length   = hdr.length_word;
      res.is_final         = hdr.flags_byte[FLAG_PUSH];
    end else begin
      res.action = ACT_SKIPPED;
    end
  end

endmodule

### rtl/ddphc_out_reg.sv
module ddphc_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  ddphc_pkg::res_t res_in,
  input  logic            res_stall,
  output logic            res_valid,
  output logic            free,
  output ddphc_pkg::res_t res_out
);
  import ddphc_pkg::*;

  assign free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (free) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

### rtl/ddp_header_classifier_top.sv
// DDP header classifier: takes one assembled datagram header per item on the hdr channel and
// returns one classification item on the res channel. An item passes an input register, one
// level of decode logic and a result register; it waits in the input register while the result
// register is blocked, and a new item is taken in every cycle while the result side keeps up;
// the sequence check and update of the stored 4-bit sequence number sets that rate.
// Configuration registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the block is idle, and the block itself does not enforce it.
module ddp_header_classifier_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic        hdr_valid,
  output logic        hdr_stall,
  input  logic [7:0]  flags_byte,
  input  logic [7:0]  control_byte,
  input  logic [7:0]  type_byte,
  input  logic [7:0]  dest_id,
  input  logic [31:0] offset_word,
  input  logic [15:0] length_word,
  input  logic [15:0] datagram_length,
  input  logic [7:0]  first_payload_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  action,
  output logic [7:0]  reply_flags,
  output logic [7:0]  reply_id,
  output logic [2:0]  pixel_format,
  output logic [5:0]  bits_per_element,
  output logic [31:0] data_offset,
  output logic [15:0] payload_length,
  output logic        is_final,
  output logic [7:0]  start_code,
  output logic [3:0]  payload_start
);
  import ddphc_pkg::*;
  `include "ddp_header_classifier_top_assert.svh"

  hdr_t     hdr_in;
  hdr_t     held;
  logic     held_valid;
  logic     free;
  logic     take;
  res_t     res_comb;
  res_t     res_out;
  seq_upd_t seq_upd;
  logic [3:0] last_sequence;
  logic     pause_data;
  logic [1:0] reply_version;

  assign hdr_in = '{
    flags_byte:         flags_byte,
    control_byte:       control_byte,
    type_byte:          type_byte,
    dest_id:            dest_id,
    offset_word:        offset_word,
    length_word:        length_word,
    datagram_length:    datagram_length,
    first_payload_byte: first_payload_byte
  };

  assign take = held_valid && free;

  ddphc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .hdr_valid  (hdr_valid),
    .hdr_stall  (hdr_stall),
    .hdr_in     (hdr_in),
    .take       (take),
    .held_valid (held_valid),
    .held       (held)
  );

  ddphc_classify u_classify (
    .hdr           (held),
    .last_sequence (last_sequence),
    .pause_data    (pause_data),
    .reply_version (reply_version),
    .res           (res_comb),
    .seq_upd       (seq_upd)
  );

  ddphc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .res_in    (res_comb),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .free      (free),
    .res_out   (res_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sequence <= 4'd0;
      pause_data    <= 1'b0;
      reply_version <= 2'd1;
    end else begin
      if (take && seq_upd.write) begin
        last_sequence <= seq_upd.value;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAUSE_DATA:    pause_data    <= cfg_data[0];
          CFG_REPLY_VERSION: reply_version <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign action           = res_out.action;
  assign reply_flags      = res_out.reply_flags;
  assign reply_id         = res_out.reply_id;
  assign pixel_format     = res_out.pixel_format;
  assign bits_per_element = res_out.bits_per_element;
  assign data_offset      = res_out.data_offset;
  assign payload_length   = res_out.payload_length;
  assign is_final         = res_out.is_final;
  assign start_code       = res_out.start_code;
  assign payload_start    = res_out.payload_start;

  `DDPHC_ASSERT_NOW(a_stall_when_blocked, held_valid && res_valid && res_stall, hdr_stall,
    "held item not stalled while result is blocked")
  `DDPHC_ASSERT_NEXT(a_take_gives_result, take, res_valid,
    "item taken but no result shown")
  `DDPHC_ASSERT_NOW(a_seq_moves_on_take, !$stable(last_sequence), $past(take),
    "sequence number changed without an item")
  `DDPHC_ASSERT_NOW(a_reply_only_query,
    res_valid && res_out.action != ACT_STATUS_QRY && res_out.action != ACT_OTHER_QRY,
    reply_flags == 8'd0 && reply_id == 8'd0,
    "reply fields set on a non-query result")

endmodule
